// File: rtl/ffs_pkg.sv
// shared types and constants of the forest-fire stencil step
`default_nettype none

package ffs_pkg;

  // configuration port
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 7;
  localparam int PCT_W     = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIDE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CATCH_PCT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NEIGH_THR = 2'd2;

  localparam int MIN_SIDE       = 5;
  localparam int SIDE_RST_VALUE = 10;
  localparam logic [PCT_W-1:0] CATCH_RST = 7'd30;
  localparam logic [PCT_W-1:0] THR_RST   = 7'd25;

  // percent scale of the burning share test
  localparam int PROD_W    = 11;
  localparam int PCT_SCALE = 100;

  // burn count saturation and change counter
  localparam logic [1:0] BURN_MAX = 2'd3;
  localparam int CHG_W = 13;
  localparam logic [CHG_W-1:0] CHG_MAX = 13'd8191;

  typedef enum logic [1:0] {
    CELL_EMPTY   = 2'd0,
    CELL_TREE    = 2'd1,
    CELL_BURNING = 2'd2,
    CELL_BURNED  = 2'd3
  } cell_state_e;

  // one stored cell: burn count above state
  typedef struct packed {
    logic [1:0]  burn;
    cell_state_e state;
  } cell_t;

  localparam int CELL_W = $bits(cell_t);

  // 3x3 neighbourhood, index (row * 3) + column, oldest row first
  typedef cell_t [8:0] win_t;

  // which sides of the centre cell lie on the grid border
  typedef struct packed {
    logic at_top;
    logic at_bottom;
    logic at_left;
    logic at_right;
  } nbr_edge_t;

  typedef struct packed {
    cell_state_e next_state;
    logic [1:0]  next_burn;
    logic        changed;
  } rule_res_t;

endpackage

`default_nettype wire

// File: rtl/ffs_in_if.sv
// input channel: one grid cell per beat
`default_nettype none

interface ffs_in_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 cell_state;
  logic [1:0]                 burn_count;
  logic [ffs_pkg::PCT_W-1:0]  random_pct;
  logic                       flush;

  modport source (output valid, output cell_state, output burn_count,
                  output random_pct, output flush, input ready);
  modport sink   (input valid, input cell_state, input burn_count,
                  input random_pct, input flush, output ready);
endinterface

`default_nettype wire

// File: rtl/ffs_out_if.sv
// output channel: next-generation cell per beat
`default_nettype none

interface ffs_out_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 next_state;
  logic [1:0]                 next_burn_count;
  logic                       changed;
  logic                       last_of_frame;
  logic [ffs_pkg::CHG_W-1:0]  frame_changes;
  logic                       fire_out;

  modport source (output valid, output next_state, output next_burn_count,
                  output changed, output last_of_frame, output frame_changes,
                  output fire_out, input ready);
  modport sink   (input valid, input next_state, input next_burn_count,
                  input changed, input last_of_frame, input frame_changes,
                  input fire_out, output ready);
endinterface

`default_nettype wire

// File: rtl/fire_spread_stencil_step.sv
// top level of the streaming forest-fire generation step
`default_nettype none

// one generation of a forest-fire automaton over a square grid of grid_side
// cells a side; cells enter in raster order, one beat per cell, and one beat
// can be taken every clock cycle unless the output stalls, set by the single
// line-store ram port pair and a two-register pipe (window register, then
// result register); after the last cell the producer sends grid_side+1 flush
// beats, and the result for a cell leaves grid_side+1 input beats after that
// cell went in, passing the window and result registers; flush beats yield
// results only while the window still holds grid cells; the result for the
// final cell has last_of_frame set, carries the frame's change count and the
// fire-out flag; the line stores need no clearing pass after reset, since a
// per-column valid bit makes an unwritten column read as empty; writing
// grid_side restarts the frame and must only be done with the block idle
module fire_spread_stencil_step #(
  parameter int MAX_SIDE = 64
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [ffs_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [ffs_pkg::CFG_W-1:0]     cfg_data_i,
  ffs_in_if.sink                             in_ch,
  ffs_out_if.source                          out_ch
);

  import ffs_pkg::*;

  localparam int COL_W = $clog2(MAX_SIDE);
  localparam int ROW_W = $clog2(MAX_SIDE + 2);
  localparam int SIDE_RST = (SIDE_RST_VALUE < MAX_SIDE) ? SIDE_RST_VALUE : MAX_SIDE;

  // configuration
  logic [ROW_W-1:0] side_q;
  logic [PCT_W-1:0] catch_q;
  logic [PCT_W-1:0] thr_q;
  logic             side_wr;
  logic             catch_wr;
  logic             thr_wr;
  logic [31:0]      cfg_wide;
  logic [ROW_W-1:0] side_clamped;

  // frame position and frame flags
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [ROW_W-1:0] col_ext;
  logic [ROW_W-1:0] col_inc;
  logic [ROW_W-1:0] side_p1;
  logic             saw_q, saw_d;
  logic [CHG_W-1:0] chg_total_q, chg_total_d;

  // input beat decode
  logic      in_accept;
  logic      in_grid;
  logic      emit;
  logic      last;
  cell_t     pix;
  nbr_edge_t edge_now;

  // window stage
  cell_t            tap_a;
  cell_t            tap_b;
  win_t             win_q, win_d;
  logic             a_vld_q;
  nbr_edge_t        a_edge_q;
  logic [PCT_W-1:0] a_rnd_q;
  logic             a_last_q;
  logic             a_fire_out_q;
  logic             a_move;

  // result stage
  rule_res_t        rule_res;
  logic             b_vld_q;
  logic             b_free;
  rule_res_t        b_res_q;
  logic             b_last_q;
  logic             b_fire_out_q;
  logic [CHG_W-1:0] b_chg_q;
  logic [CHG_W-1:0] chg_new;

  // register write decode
  always_comb begin
    side_wr  = 1'b0;
    catch_wr = 1'b0;
    thr_wr   = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_GRID_SIDE: side_wr  = 1'b1;
        CFG_CATCH_PCT: catch_wr = 1'b1;
        CFG_NEIGH_THR: thr_wr   = 1'b1;
        default: begin
        end
      endcase
    end
  end

  // side held within the supported range
  always_comb begin
    cfg_wide = 32'(cfg_data_i);
    if (cfg_wide < 32'(MIN_SIDE)) begin
      side_clamped = ROW_W'(MIN_SIDE);
    end else if (cfg_wide > 32'(MAX_SIDE)) begin
      side_clamped = ROW_W'(MAX_SIDE);
    end else begin
      side_clamped = ROW_W'(cfg_wide);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q  <= ROW_W'(SIDE_RST);
      catch_q <= CATCH_RST;
      thr_q   <= THR_RST;
    end else begin
      if (side_wr) begin
        side_q <= side_clamped;
      end
      if (catch_wr) begin
        catch_q <= cfg_data_i;
      end
      if (thr_wr) begin
        thr_q <= cfg_data_i;
      end
    end
  end

  // handshake: window stage frees when it is empty or hands over this cycle
  assign b_free       = !b_vld_q || out_ch.ready;
  assign a_move       = a_vld_q && b_free;
  assign in_ch.ready  = !a_vld_q || b_free;
  assign in_accept    = in_ch.valid && in_ch.ready;

  assign col_ext = ROW_W'(col_q);
  assign col_inc = col_ext + ROW_W'(1);
  assign side_p1 = side_q + ROW_W'(1);

  // position decode: results start once the window centre is a grid cell,
  // the final cell is emitted at column zero two rows below the grid's end
  always_comb begin
    in_grid = row_q < side_q;
    emit    = (row_q >= ROW_W'(2)) || ((row_q == ROW_W'(1)) && (col_q != '0));
    last    = (col_q == '0) && (row_q == side_p1);
    pix     = '0;
    if (in_grid && !in_ch.flush) begin
      pix.state = cell_state_e'(in_ch.cell_state);
      pix.burn  = in_ch.burn_count;
    end
    if (col_q != '0) begin
      edge_now.at_top    = row_q == ROW_W'(1);
      edge_now.at_bottom = row_q == side_q;
      edge_now.at_left   = col_q == COL_W'(1);
      edge_now.at_right  = 1'b0;
    end else begin
      // centre is the last column of the row before last
      edge_now.at_top    = row_q == ROW_W'(2);
      edge_now.at_bottom = row_q == side_p1;
      edge_now.at_left   = 1'b0;
      edge_now.at_right  = 1'b1;
    end
  end

  // next position and frame flags
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    saw_d = saw_q;
    if (side_wr) begin
      col_d = '0;
      row_d = '0;
      saw_d = 1'b0;
    end else if (in_accept) begin
      if (last) begin
        col_d = '0;
        row_d = '0;
        saw_d = 1'b0;
      end else begin
        if (in_grid && !in_ch.flush && pix.state == CELL_BURNING) begin
          saw_d = 1'b1;
        end
        if (col_inc == side_q) begin
          col_d = '0;
          row_d = row_q + ROW_W'(1);
        end else begin
          col_d = COL_W'(col_inc);
        end
      end
    end
  end

  // line stores; read address runs one beat ahead of the write
  ffs_line_buf #(.DEPTH(MAX_SIDE)) u_line_buf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (in_accept),
    .wr_addr_i (col_q),
    .wr_data_i (pix),
    .rd_addr_i (col_d),
    .tap_a_o   (tap_a),
    .tap_b_o   (tap_b)
  );

  // window shifts left, new column enters on the right
  always_comb begin
    win_d = win_q;
    if (in_accept) begin
      for (int r = 0; r < 3; r++) begin
        win_d[r*3]   = win_q[r*3+1];
        win_d[r*3+1] = win_q[r*3+2];
      end
      win_d[2] = tap_b;
      win_d[5] = tap_a;
      win_d[8] = pix;
    end
  end

  ffs_rule u_rule (
    .win_i   (win_q),
    .edge_i  (a_edge_q),
    .rnd_i   (a_rnd_q),
    .catch_i (catch_q),
    .thr_i   (thr_q),
    .res_o   (rule_res)
  );

  // running change count, saturating
  always_comb begin
    chg_new     = chg_total_q;
    chg_total_d = chg_total_q;
    if (rule_res.changed && chg_total_q != CHG_MAX) begin
      chg_new = chg_total_q + CHG_W'(1);
    end
    if (side_wr) begin
      chg_total_d = '0;
    end else if (a_move) begin
      chg_total_d = a_last_q ? '0 : chg_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      saw_q       <= 1'b0;
      chg_total_q <= '0;
      win_q       <= '0;
      a_vld_q     <= 1'b0;
      b_vld_q     <= 1'b0;
    end else begin
      col_q       <= col_d;
      row_q       <= row_d;
      saw_q       <= saw_d;
      chg_total_q <= chg_total_d;
      win_q       <= win_d;
      if (in_accept) begin
        a_vld_q <= emit;
      end else if (a_move) begin
        a_vld_q <= 1'b0;
      end
      if (a_move) begin
        b_vld_q <= 1'b1;
      end else if (out_ch.ready) begin
        b_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      a_edge_q     <= edge_now;
      a_rnd_q      <= in_ch.random_pct;
      a_last_q     <= last;
      a_fire_out_q <= last && !saw_q;
    end
    if (a_move) begin
      b_res_q      <= rule_res;
      b_last_q     <= a_last_q;
      b_fire_out_q <= a_fire_out_q;
      b_chg_q      <= chg_new;
    end
  end

  assign out_ch.valid           = b_vld_q;
  assign out_ch.next_state      = b_res_q.next_state;
  assign out_ch.next_burn_count = b_res_q.next_burn;
  assign out_ch.changed         = b_res_q.changed;
  assign out_ch.last_of_frame   = b_last_q;
  assign out_ch.frame_changes   = b_chg_q;
  assign out_ch.fire_out        = b_fire_out_q;

  // fire-out is only reported on the final cell
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && out_ch.fire_out) |-> out_ch.last_of_frame)
    else $error("fire_out outside the final cell");

  // a changed cell is always counted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && out_ch.changed) |-> (out_ch.frame_changes != '0))
    else $error("changed cell with zero change count");

  // a stalled window stage keeps its item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_vld_q && !b_free) |=> (a_vld_q && $stable(a_rnd_q) && $stable(win_q)))
    else $error("window stage lost its item under stall");

  // frame position stays inside the frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (col_ext < side_q) && (row_q <= side_p1))
    else $error("frame position out of range");

endmodule

`default_nettype wire

// File: rtl/ffs_ram.sv
// generic single-write, single-read ram with registered read
`default_nettype none

module ffs_ram #(
  parameter  int WIDTH  = 4,
  parameter  int DEPTH  = 64,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output      logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read-first on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/ffs_line_buf.sv
// two chained line stores with per-column valid bits and write bypass
`default_nettype none

module ffs_line_buf #(
  parameter  int DEPTH  = 64,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 wr_en_i,
  input  wire logic [ADDR_W-1:0]    wr_addr_i,
  input  wire ffs_pkg::cell_t       wr_data_i,
  input  wire logic [ADDR_W-1:0]    rd_addr_i,
  output      ffs_pkg::cell_t       tap_a_o,
  output      ffs_pkg::cell_t       tap_b_o
);

  import ffs_pkg::*;

  logic [DEPTH-1:0]  vld_q;
  logic              rd_vld_q;
  logic              byp_q;
  cell_t             byp_a_q;
  cell_t             byp_b_q;
  logic [CELL_W-1:0] ram_a_rd;
  logic [CELL_W-1:0] ram_b_rd;
  logic              hit;

  // next column read while current column is written; equal only on restart
  assign hit = wr_en_i && (wr_addr_i == rd_addr_i);

  ffs_ram #(.WIDTH(CELL_W), .DEPTH(DEPTH)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (wr_en_i),
    .waddr_i (wr_addr_i),
    .wdata_i (wr_data_i),
    .raddr_i (rd_addr_i),
    .rdata_o (ram_a_rd)
  );

  // store b takes the row that leaves store a
  ffs_ram #(.WIDTH(CELL_W), .DEPTH(DEPTH)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (wr_en_i),
    .waddr_i (wr_addr_i),
    .wdata_i (tap_a_o),
    .raddr_i (rd_addr_i),
    .rdata_o (ram_b_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
      byp_q    <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      rd_vld_q <= vld_q[rd_addr_i];
      byp_q    <= hit;
    end
  end

  always_ff @(posedge clk_i) begin
    byp_a_q <= wr_data_i;
    byp_b_q <= tap_a_o;
  end

  // never-written columns read as empty cells
  always_comb begin
    if (byp_q) begin
      tap_a_o = byp_a_q;
      tap_b_o = byp_b_q;
    end else if (rd_vld_q) begin
      tap_a_o = cell_t'(ram_a_rd);
      tap_b_o = cell_t'(ram_b_rd);
    end else begin
      tap_a_o = '0;
      tap_b_o = '0;
    end
  end

endmodule

`default_nettype wire

// File: rtl/ffs_rule.sv
// forest-fire transition rule for the centre of one 3x3 window
`default_nettype none

module ffs_rule (
  input  wire ffs_pkg::win_t                 win_i,
  input  wire ffs_pkg::nbr_edge_t            edge_i,
  input  wire logic [ffs_pkg::PCT_W-1:0]     rnd_i,
  input  wire logic [ffs_pkg::PCT_W-1:0]     catch_i,
  input  wire logic [ffs_pkg::PCT_W-1:0]     thr_i,
  output      ffs_pkg::rule_res_t            res_o
);

  import ffs_pkg::*;

  logic [2:0]        row_ok;
  logic [2:0]        col_ok;
  logic [8:0]        nbr_en;
  logic [3:0]        burning;
  logic [3:0]        trees;
  logic [PROD_W-1:0] burn_scaled;
  logic [PROD_W-1:0] thr_scaled;
  logic              ignite;
  logic [1:0]        burn_inc;
  cell_t             centre;

  assign row_ok = {!edge_i.at_bottom, 1'b1, !edge_i.at_top};
  assign col_ok = {!edge_i.at_right, 1'b1, !edge_i.at_left};
  assign centre = win_i[4];

  // off-grid neighbours count as empty
  always_comb begin
    burning = '0;
    trees   = '0;
    nbr_en  = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        nbr_en[r*3+c] = row_ok[r] && col_ok[c] && !(r == 1 && c == 1);
        if (nbr_en[r*3+c] && win_i[r*3+c].state == CELL_BURNING) begin
          burning = burning + 4'd1;
        end
        if (nbr_en[r*3+c] && (win_i[r*3+c].state == CELL_TREE ||
                              win_i[r*3+c].state == CELL_BURNING)) begin
          trees = trees + 4'd1;
        end
      end
    end
  end

  // burning share test kept exact in integers
  assign burn_scaled = PROD_W'(burning) * PROD_W'(PCT_SCALE);
  assign thr_scaled  = PROD_W'(thr_i) * PROD_W'(trees);
  assign ignite      = (trees != '0) && (burn_scaled >= thr_scaled) && (rnd_i < catch_i);
  assign burn_inc    = (centre.burn == BURN_MAX) ? BURN_MAX : centre.burn + 2'd1;

  always_comb begin
    res_o.next_state = centre.state;
    res_o.next_burn  = centre.burn;
    res_o.changed    = 1'b0;
    case (centre.state)
      CELL_BURNING: begin
        res_o.next_burn  = burn_inc;
        res_o.next_state = (burn_inc == BURN_MAX) ? CELL_BURNED : CELL_BURNING;
        res_o.changed    = 1'b1;
      end
      CELL_TREE: begin
        if (ignite) begin
          res_o.next_state = CELL_BURNING;
          res_o.next_burn  = '0;
          res_o.changed    = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire
